// ----- rtl/rlmav_pkg.sv -----
package rlmav_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int SCALE_W     = 24;
    localparam int DELAY_W     = 16;
    localparam int VOLT_W      = 38;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 24;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(0);
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE   = 1'b0,
        REG_MIN_GAP = 1'b1
    } cfg_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic update;
        logic mul;
        logic div;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic take;
        logic div_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ----- rtl/rlmav_ctrl.sv -----
module rlmav_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  rlmav_pkg::ctrl_sts_t  sts,
    output rlmav_pkg::ctrl_cmd_t  cmd
);
    import rlmav_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_UPDATE = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    // A tick that takes no sample only repeats the last voltage.
                    state_next = sts.take ? S_UPDATE : S_DONE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ----- rtl/rlmav_datapath.sv -----
module rlmav_datapath #(
    parameter int WINDOW = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rlmav_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlmav_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rlmav_pkg::SAMPLE_W-1:0]     sample,
    input  rlmav_pkg::ctrl_cmd_t               cmd,
    output rlmav_pkg::ctrl_sts_t               sts,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic                               updated,
    output logic                               changed,
    output logic [rlmav_pkg::VOLT_W-1:0]       voltage
);
    import rlmav_pkg::*;

    localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W     = $clog2(WINDOW + 1);
    localparam int SUM_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
    localparam int PROD_W    = SCALE_W + SUM_W;
    localparam int DIV_STEPS = (PROD_W + 1) / 2;
    localparam int DIV_W     = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration registers.
    logic [SCALE_W-1:0]  scale_reg;
    logic [DELAY_W-1:0]  delay_reg;

    // Filter state.
    logic [SAMPLE_W-1:0] mem [WINDOW];
    logic [SAMPLE_W-1:0] old_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [DELAY_W-1:0]  elapsed_reg;
    logic [DELAY_W-1:0]  elapsed_inc;
    logic                take_reg;
    logic                take;
    logic                full;
    logic [VOLT_W-1:0]   last_voltage_reg;

    // Divider.
    logic [DIV_W-1:0]    quo_reg;
    logic [DIV_W-1:0]    quo_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [CNT_W:0]      trial;
    logic [STEP_W-1:0]   step_reg;
    logic [PROD_W-1:0]   product;
    logic [DIV_W+VOLT_W-1:0] quo_ext;
    logic [VOLT_W-1:0]   result;

    // Output register.
    logic                out_valid_reg;
    logic                updated_reg;
    logic                changed_reg;
    logic [VOLT_W-1:0]   voltage_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
            delay_reg <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCALE:   scale_reg <= cfg_data[SCALE_W-1:0];
                REG_MIN_GAP: delay_reg <= cfg_data[DELAY_W-1:0];
                default:     ;
            endcase
        end
    end

    // The tick counter saturates at its all-ones value.
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + DELAY_W'(1);
    assign take        = (elapsed_inc >= delay_reg);
    assign full        = (count_reg == CNT_W'(WINDOW));

    // The slot at the write pointer holds the oldest sample once the window is full.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            old_reg <= mem[ptr_reg];
            if (take)
            begin
                mem[ptr_reg] <= sample;
            end
        end
    end

    always_comb
    begin
        sum_next = sum_reg + SUM_W'(sample_reg);
        if (full)
        begin
            sum_next = sum_next - SUM_W'(old_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            take_reg    <= 1'b0;
            ptr_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                take_reg    <= take;
                elapsed_reg <= take ? '0 : elapsed_inc;
                if (take)
                begin
                    ptr_reg <= (ptr_reg == PTR_W'(WINDOW - 1)) ? '0 : ptr_reg + PTR_W'(1);
                end
            end
            if (cmd.update)
            begin
                sum_reg <= sum_next;
                if (!full)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    assign product = PROD_W'(scale_reg) * PROD_W'(sum_reg);

    // Restoring division, two quotient bits per cycle.
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, count_reg})
            begin
                rem_next    = CNT_W'(trial - {1'b0, count_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            quo_reg  <= DIV_W'(product);
            rem_reg  <= '0;
            step_reg <= STEP_W'(DIV_STEPS - 1);
        end
        else if (cmd.div)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    assign quo_ext = {{VOLT_W{1'b0}}, quo_reg};
    assign result  = quo_ext[VOLT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            last_voltage_reg <= '0;
        end
        else
        begin
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                if (take_reg)
                begin
                    last_voltage_reg <= result;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            updated_reg <= take_reg;
            changed_reg <= take_reg && (result != last_voltage_reg);
            voltage_reg <= take_reg ? result : last_voltage_reg;
        end
    end

    assign sts.take     = take;
    assign sts.div_last = (step_reg == '0);
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign updated   = updated_reg;
    assign changed   = changed_reg;
    assign voltage   = voltage_reg;

endmodule

// ----- rtl/rate_limited_moving_average_voltage_core.sv -----
// A tick that takes a sample passes through the update, multiply and divide states,
// then waits in the done state until the output is free; a tick without a sample
// goes from idle straight to the done state. Items are taken one at a time (in_stall
// is high outside idle), and the divider retires 2 bits a cycle.
// Reset (rst_n, asynchronous, active low) empties the window, clears sum, count,
// tick counter and last voltage, and sets scale to 0 and the minimum tick gap to 100.
module rate_limited_moving_average_voltage_core #(
    parameter int WINDOW = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rlmav_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rlmav_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rlmav_pkg::SAMPLE_W-1:0]     sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               updated,
    output logic                               changed,
    output logic [rlmav_pkg::VOLT_W-1:0]       voltage
);
    import rlmav_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    rlmav_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlmav_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .sts       (sts),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .updated   (updated),
        .changed   (changed),
        .voltage   (voltage)
    );

endmodule

// ----- rtl/rlmav_checker.sv -----
module rlmav_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               updated,
    input  logic                               changed,
    input  logic [rlmav_pkg::VOLT_W-1:0]       voltage
);
    import rlmav_pkg::*;

    logic [VOLT_W-1:0] seen_reg;

    // Last voltage delivered on the output channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            seen_reg <= voltage;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(voltage) && $stable(updated))
        else $error("stalled output item changed");

    a_no_update_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !updated |-> !changed)
        else $error("changed set on a tick without a sample");

    a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !updated |-> voltage == seen_reg)
        else $error("voltage moved on a tick without a sample");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && updated |-> changed == (voltage != seen_reg))
        else $error("changed flag disagrees with the voltage");

endmodule

bind rate_limited_moving_average_voltage_core rlmav_checker u_rlmav_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .updated   (updated),
    .changed   (changed),
    .voltage   (voltage)
);
